// File: src/rbc_pkg.sv
// shared constants, types and byte functions of the rijndael core
`default_nettype none
package rbc_pkg;

	localparam int MAX_BLOCK_COLUMNS = 8;
	localparam int MAX_KEY_COLUMNS = 8;
	localparam int MAX_ROUND_COUNT = 14;
	localparam int MAX_WORDS = MAX_BLOCK_COLUMNS / 2;
	localparam int RK_ROWS = MAX_ROUND_COUNT + 1;
	localparam int ROW_W = 32 * MAX_BLOCK_COLUMNS;

	// register indexes of the configuration port
	localparam logic [2:0] REG_KEY_SIZE = 3'd0;
	localparam logic [2:0] REG_BLOCK_SIZE = 3'd1;
	localparam logic [2:0] REG_DIRECTION = 3'd2;
	localparam logic [2:0] REG_CHAINING = 3'd3;
	localparam logic [2:0] REG_KEY_WORD_0 = 3'd4;
	localparam logic [2:0] REG_KEY_WORD_1 = 3'd5;
	localparam logic [2:0] REG_KEY_WORD_2 = 3'd6;
	localparam logic [2:0] REG_KEY_WORD_3 = 3'd7;

	typedef logic [MAX_BLOCK_COLUMNS-1:0][31:0] col_row_t;

	typedef struct packed {
		logic load;
		logic run;
		logic encrypt;
		logic mix;
		logic [3:0] bc;
	} round_ctl_t;

	typedef struct packed {
		logic start;
		logic [3:0] kc;
		logic [3:0] bc;
		logic [3:0] nr;
		logic [3:0] rd_row;
	} ks_ctl_t;

	localparam logic [2047:0] SBOX_TABLE = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	localparam logic [2047:0] INV_SBOX_TABLE = {
		128'h52096ad53036a538bf40a39e81f3d7fb,
		128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e,
		128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692,
		128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506,
		128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673,
		128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b,
		128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f,
		128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961,
		128'h172b047eba77d626e169146355210c7d
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return SBOX_TABLE[{~b, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] b);
		return INV_SBOX_TABLE[{~b, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a [4];
		logic [7:0] b [4];
		for (int i = 0; i < 4; i++) a[i] = c[31-8*i -: 8];
		for (int i = 0; i < 4; i++) begin
			b[i] = xtime(a[i]) ^ xtime(a[(i+1)%4]) ^ a[(i+1)%4] ^ a[(i+2)%4] ^ a[(i+3)%4];
		end
		return {b[0], b[1], b[2], b[3]};
	endfunction

	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		logic [7:0] x2;
		logic [7:0] x4;
		logic [7:0] x8;
		logic [7:0] b [4];
		for (int i = 0; i < 4; i++) begin
			a[i] = c[31-8*i -: 8];
			x2 = xtime(a[i]);
			x4 = xtime(x2);
			x8 = xtime(x4);
			m9[i] = x8 ^ a[i];
			mb[i] = x8 ^ x2 ^ a[i];
			md[i] = x8 ^ x4 ^ a[i];
			me[i] = x8 ^ x4 ^ x2;
		end
		for (int i = 0; i < 4; i++) begin
			b[i] = me[i] ^ mb[(i+1)%4] ^ md[(i+2)%4] ^ m9[(i+3)%4];
		end
		return {b[0], b[1], b[2], b[3]};
	endfunction

	// column count for a size code, dropped to what the limit allows
	function automatic logic [3:0] cols_for(input logic [1:0] code, input int limit);
		logic [1:0] c;
		c = (code > 2'd2) ? 2'd2 : code;
		if (c == 2'd2 && limit < 8) c = 2'd1;
		if (c == 2'd1 && limit < 6) c = 2'd0;
		return 4'd4 + {1'b0, c, 1'b0};
	endfunction

	function automatic logic [3:0] round_count(input logic [3:0] kc, input logic [3:0] bc);
		logic [3:0] m;
		logic [4:0] n;
		m = (kc > bc) ? kc : bc;
		n = 5'd6 + {1'b0, m};
		if (n > 5'(MAX_ROUND_COUNT)) n = 5'(MAX_ROUND_COUNT);
		return n[3:0];
	endfunction

	// rotation of one state row in columns
	function automatic logic [3:0] shift_amt(input logic [1:0] r, input logic [3:0] bc,
			input logic inverse);
		logic [3:0] s;
		s = {2'b00, r};
		if (bc == 4'd8 && r >= 2'd2) s = s + 4'd1;
		if (inverse) s = bc - s;
		return s;
	endfunction

endpackage
`default_nettype wire

// File: src/rbc_key_sched.sv
// key expansion, one key column a cycle, into a round key memory of one row a round
`default_nettype none
module rbc_key_sched (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rbc_pkg::ks_ctl_t    ctl,
	input  wire logic [63:0]         key_word_0,
	input  wire logic [63:0]         key_word_1,
	input  wire logic [63:0]         key_word_2,
	input  wire logic [63:0]         key_word_3,
	output logic                     done,
	output rbc_pkg::col_row_t        rk_row
);

	logic [rbc_pkg::ROW_W-1:0] rk_mem [rbc_pkg::RK_ROWS];

	logic        busy_q;
	logic [6:0]  c_q;
	logic [2:0]  kmod_q;
	logic [2:0]  col_q;
	logic [3:0]  row_q;
	logic [7:0]  rcon_q;
	logic [31:0] win_q [rbc_pkg::MAX_KEY_COLUMNS];
	rbc_pkg::col_row_t row_buf_q;
	rbc_pkg::col_row_t rd_q;

	logic [7:0]  total;
	logic [31:0] key_col;
	logic [31:0] t;
	logic [31:0] new_col;
	logic [63:0] kw;
	logic        row_full;
	logic        last_col;
	rbc_pkg::col_row_t row_wr;

	assign total = 8'({4'd0, ctl.nr} + 8'd1) * 8'({4'd0, ctl.bc});

	always_comb begin
		case (c_q[2:1])
			2'd0: kw = key_word_0;
			2'd1: kw = key_word_1;
			2'd2: kw = key_word_2;
			default: kw = key_word_3;
		endcase
		key_col = c_q[0] ? kw[31:0] : kw[63:32];
		t = win_q[0];
		if (kmod_q == 3'd0) begin
			t = rbc_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'd0};
		end else if (ctl.kc == 4'd8 && kmod_q == 3'd4) begin
			t = rbc_pkg::sub_word(t);
		end
		// the first key columns come straight from the key registers
		if ({1'b0, c_q} < {4'd0, ctl.kc}) new_col = key_col;
		else new_col = win_q[3'(ctl.kc - 4'd1)] ^ t;
		row_wr = row_buf_q;
		row_wr[col_q] = new_col;
		row_full = ({1'b0, col_q} == ctl.bc - 4'd1);
		last_col = ({1'b0, c_q} == total - 8'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			c_q <= '0;
			kmod_q <= '0;
			col_q <= '0;
			row_q <= '0;
			rcon_q <= 8'h01;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				c_q <= '0;
				kmod_q <= '0;
				col_q <= '0;
				row_q <= '0;
				rcon_q <= 8'h01;
			end else if (busy_q) begin
				c_q <= c_q + 7'd1;
				if ({1'b0, kmod_q} == ctl.kc - 4'd1) kmod_q <= '0;
				else kmod_q <= kmod_q + 3'd1;
				if ({1'b0, c_q} >= {4'd0, ctl.kc} && kmod_q == 3'd0) rcon_q <= rbc_pkg::xtime(rcon_q);
				if (row_full) begin
					col_q <= '0;
					row_q <= row_q + 4'd1;
				end else begin
					col_q <= col_q + 3'd1;
				end
				if (last_col) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			win_q[0] <= new_col;
			for (int i = 1; i < rbc_pkg::MAX_KEY_COLUMNS; i++) win_q[i] <= win_q[i-1];
			row_buf_q <= row_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && row_full) rk_mem[row_q] <= row_wr;
		rd_q <= rk_mem[ctl.rd_row];
	end

	assign rk_row = rd_q;

endmodule
`default_nettype wire

// File: src/rbc_round.sv
// shared round unit: one full rijndael round a cycle on the state register
`default_nettype none
module rbc_round (
	input  wire logic                 clk,
	input  wire rbc_pkg::round_ctl_t  ctl,
	input  wire rbc_pkg::col_row_t    src,
	input  wire rbc_pkg::col_row_t    rk,
	output rbc_pkg::col_row_t         state
);

	rbc_pkg::col_row_t st_q;
	rbc_pkg::col_row_t sb;
	rbc_pkg::col_row_t sh;
	rbc_pkg::col_row_t im;
	rbc_pkg::col_row_t ish;
	rbc_pkg::col_row_t nxt;

	always_comb begin
		logic [3:0] s;
		logic [3:0] t;
		// forward: substitute, shift rows, mix columns; inverse: the reverse order
		for (int j = 0; j < rbc_pkg::MAX_BLOCK_COLUMNS; j++) begin
			sb[j] = rbc_pkg::sub_word(st_q[j]);
			im[j] = ctl.mix ? rbc_pkg::inv_mix_col(st_q[j]) : st_q[j];
		end
		sh = sb;
		ish = im;
		for (int i = 1; i < 4; i++) begin
			for (int j = 0; j < rbc_pkg::MAX_BLOCK_COLUMNS; j++) begin
				s = rbc_pkg::shift_amt(2'(i), ctl.bc, 1'b0);
				t = 4'(j) + s;
				if (t >= ctl.bc) t = t - ctl.bc;
				sh[j][31-8*i -: 8] = sb[t[2:0]][31-8*i -: 8];
				s = rbc_pkg::shift_amt(2'(i), ctl.bc, 1'b1);
				t = 4'(j) + s;
				if (t >= ctl.bc) t = t - ctl.bc;
				ish[j][31-8*i -: 8] = im[t[2:0]][31-8*i -: 8];
			end
		end
		for (int j = 0; j < rbc_pkg::MAX_BLOCK_COLUMNS; j++) begin
			if (ctl.load) nxt[j] = src[j] ^ rk[j];
			else if (ctl.encrypt) nxt[j] = (ctl.mix ? rbc_pkg::mix_col(sh[j]) : sh[j]) ^ rk[j];
			else nxt[j] = {rbc_pkg::inv_sbox(ish[j][31:24]), rbc_pkg::inv_sbox(ish[j][23:16]),
				rbc_pkg::inv_sbox(ish[j][15:8]), rbc_pkg::inv_sbox(ish[j][7:0])} ^ rk[j];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.run) st_q <= nxt;
	end

	assign state = st_q;

endmodule
`default_nettype wire

// File: src/rijndael_block_cipher_ecb_cbc_core.sv
// Rijndael ECB/CBC core, 128/192/256-bit keys and blocks, 64-bit words.
// Input words arrive on the s_ stream; tuser 1 marks an IV word, 0 a data word.
// Data words fill a block of 2, 3 or 4 words; the block is then ciphered and
// its words leave on the m_ stream, tlast on the final word of the block.
// IV words load the CBC chain and discard any partial block.
// Registers are written over the APB port at byte address 8*index; the user
// must write them only while idle; the block does not enforce it. Each block's
// words are taken one a cycle while s_tvalid is high; if any register was
// written since the last block, the key schedule is rebuilt first, one key
// column a cycle, and handed over; then the first round key is fetched, the
// shared round unit adds it and runs nr = 10, 12 or 14 rounds, one a cycle,
// the result is formed, and its words leave one a cycle while m_tready is high.
// s_tready is low from the last word of a block until the last result word is
// taken, so a stalled receiver holds the whole block with its word steady.
// Reset clears the registers (direction to encrypt), the counters and the
// chain value, and marks the key schedule as stale.
`default_nettype none
module rijndael_block_cipher_ecb_cbc_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // data_word
	input  wire logic        s_tuser,   // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // out_word
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXPAND = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_RUN = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;
	localparam logic [2:0] ST_SEND = 3'd5;

	logic [2:0]  state_q;
	logic [1:0]  key_size_q;
	logic [1:0]  block_size_q;
	logic        direction_q;
	logic        chaining_q;
	logic [63:0] key_word_q [4];
	logic [1:0]  wc_q;
	logic [1:0]  ivc_q;
	logic        keys_ready_q;
	logic [3:0]  step_q;
	logic [1:0]  oidx_q;
	logic [63:0] blk_q [rbc_pkg::MAX_WORDS];
	logic [63:0] chain_q [rbc_pkg::MAX_WORDS];
	logic [63:0] out_q [rbc_pkg::MAX_WORDS];

	logic [3:0]  bc;
	logic [3:0]  kc;
	logic [3:0]  nr;
	logic [2:0]  nw;
	logic        cfg_we;
	logic        s_acc;
	logic        m_acc;
	logic        blk_full;
	logic        ks_done;
	logic [3:0]  next_k;
	rbc_pkg::ks_ctl_t   ks_ctl;
	rbc_pkg::round_ctl_t rd_ctl;
	rbc_pkg::col_row_t  src;
	rbc_pkg::col_row_t  rk_row;
	rbc_pkg::col_row_t  res;

	assign bc = rbc_pkg::cols_for(block_size_q, rbc_pkg::MAX_BLOCK_COLUMNS);
	assign kc = rbc_pkg::cols_for(key_size_q, rbc_pkg::MAX_KEY_COLUMNS);
	assign nr = rbc_pkg::round_count(kc, bc);
	assign nw = bc[3:1];

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid & s_tready;
	assign m_tvalid = (state_q == ST_SEND);
	assign m_acc = m_tvalid & m_tready;
	assign m_tdata = out_q[oidx_q];
	assign m_tlast = ({1'b0, oidx_q} == nw - 3'd1);
	assign blk_full = ({1'b0, wc_q} + 3'd1) >= nw;

	always_comb begin
		unique case (paddr[5:3])
			rbc_pkg::REG_KEY_SIZE:   prdata = {62'd0, key_size_q};
			rbc_pkg::REG_BLOCK_SIZE: prdata = {62'd0, block_size_q};
			rbc_pkg::REG_DIRECTION:  prdata = {63'd0, direction_q};
			rbc_pkg::REG_CHAINING:   prdata = {63'd0, chaining_q};
			rbc_pkg::REG_KEY_WORD_0: prdata = key_word_q[0];
			rbc_pkg::REG_KEY_WORD_1: prdata = key_word_q[1];
			rbc_pkg::REG_KEY_WORD_2: prdata = key_word_q[2];
			rbc_pkg::REG_KEY_WORD_3: prdata = key_word_q[3];
			default: prdata = '0;
		endcase
	end

	// key row for the next round step, key schedule and round controls, round input
	always_comb begin
		next_k = (step_q == nr) ? step_q : step_q + 4'd1;
		ks_ctl.start = s_acc & ~s_tuser & blk_full & ~keys_ready_q;
		ks_ctl.kc = kc;
		ks_ctl.bc = bc;
		ks_ctl.nr = nr;
		if (state_q == ST_RUN) ks_ctl.rd_row = direction_q ? next_k : nr - next_k;
		else ks_ctl.rd_row = direction_q ? 4'd0 : nr;
		rd_ctl.load = (state_q == ST_RUN) && (step_q == 4'd0);
		rd_ctl.run = (state_q == ST_RUN) && (step_q != 4'd0);
		rd_ctl.encrypt = direction_q;
		rd_ctl.mix = direction_q ? (step_q != nr) : (step_q != 4'd1);
		rd_ctl.bc = bc;
		for (int k = 0; k < rbc_pkg::MAX_WORDS; k++) begin
			logic [63:0] w;
			w = blk_q[k] ^ ((chaining_q & direction_q) ? chain_q[k] : 64'd0);
			src[2*k] = w[63:32];
			src[2*k+1] = w[31:0];
		end
	end

	rbc_key_sched u_key_sched (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ks_ctl),
		.key_word_0 (key_word_q[0]),
		.key_word_1 (key_word_q[1]),
		.key_word_2 (key_word_q[2]),
		.key_word_3 (key_word_q[3]),
		.done       (ks_done),
		.rk_row     (rk_row)
	);

	rbc_round u_round (
		.clk   (clk),
		.ctl   (rd_ctl),
		.src   (src),
		.rk    (rk_row),
		.state (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_size_q <= '0;
			block_size_q <= '0;
			direction_q <= 1'b1;
			chaining_q <= 1'b0;
			for (int i = 0; i < 4; i++) key_word_q[i] <= '0;
			wc_q <= '0;
			ivc_q <= '0;
			keys_ready_q <= 1'b0;
			step_q <= '0;
			oidx_q <= '0;
			for (int i = 0; i < rbc_pkg::MAX_WORDS; i++) chain_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				keys_ready_q <= 1'b0;
				unique case (paddr[5:3])
					rbc_pkg::REG_KEY_SIZE:   key_size_q <= pwdata[1:0];
					rbc_pkg::REG_BLOCK_SIZE: block_size_q <= pwdata[1:0];
					rbc_pkg::REG_DIRECTION:  direction_q <= pwdata[0];
					rbc_pkg::REG_CHAINING:   chaining_q <= pwdata[0];
					rbc_pkg::REG_KEY_WORD_0: key_word_q[0] <= pwdata;
					rbc_pkg::REG_KEY_WORD_1: key_word_q[1] <= pwdata;
					rbc_pkg::REG_KEY_WORD_2: key_word_q[2] <= pwdata;
					rbc_pkg::REG_KEY_WORD_3: key_word_q[3] <= pwdata;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser) begin
							chain_q[ivc_q] <= s_tdata;
							ivc_q <= (({1'b0, ivc_q} + 3'd1) >= nw) ? 2'd0 : ivc_q + 2'd1;
							wc_q <= '0;
						end else begin
							ivc_q <= '0;
							if (blk_full) begin
								wc_q <= '0;
								state_q <= keys_ready_q ? ST_PREP : ST_EXPAND;
							end else begin
								wc_q <= wc_q + 2'd1;
							end
						end
					end
				end
				ST_EXPAND: begin
					if (ks_done) begin
						keys_ready_q <= 1'b1;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					step_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					step_q <= step_q + 4'd1;
					if (step_q == nr) state_q <= ST_FIN;
				end
				ST_FIN: begin
					for (int k = 0; k < rbc_pkg::MAX_WORDS; k++) begin
						if (chaining_q && (3'(k) < nw)) begin
							chain_q[k] <= direction_q ? {res[2*k], res[2*k+1]} : blk_q[k];
						end
					end
					oidx_q <= '0;
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (m_acc) begin
						if (m_tlast) state_q <= ST_IDLE;
						else oidx_q <= oidx_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && !s_tuser) blk_q[wc_q] <= s_tdata;
		if (state_q == ST_FIN) begin
			for (int k = 0; k < rbc_pkg::MAX_WORDS; k++) begin
				out_q[k] <= {res[2*k], res[2*k+1]} ^
					((chaining_q && !direction_q) ? chain_q[k] : 64'd0);
			end
		end
	end

endmodule
`default_nettype wire

// File: src/rbc_checker.sv
// port-level checks of the rijndael core, bound to the top level
`default_nettype none
module rbc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic        pready
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// no input is taken while a block is being sent
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready during result burst");

	// the burst ends after its last word
	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("block did not return to idle after last word");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind rijndael_block_cipher_ecb_cbc_core rbc_checker u_rbc_checker (.*);
`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for the rijndael ecb/cbc core with its own cipher predictor
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_IV = 1'b1;
	localparam int SETTLE_CYCLES = 200;

	typedef struct {
		logic [63:0] word;
		logic last;
	} out_word_t;

	typedef struct {
		logic op;
		logic [63:0] data;
		int n_typed;
		logic [63:0] typed [2];
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;   // data_word
	logic s_tuser = 1'b0;        // op
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;        // out_word
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	rijndael_block_cipher_ecb_cbc_core u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [7:0] fwd_box [256];
	logic [7:0] inv_box [256];
	logic [1:0] key_code, blk_code;
	logic encrypt, cbc_on;
	logic [63:0] key_reg [4];
	logic [31:0] sched [120];
	logic [63:0] blk_buf [4];
	logic [63:0] chain [4];
	int fill_cnt, iv_cnt;
	bit sched_ok;

	out_word_t cipher_q [$];
	int n_fail, n_words, n_blocks, n_phases;
	bit no_gaps, hold_on;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		n_fail++;
		$display("tb: mismatch %s got %h want %h at %0t", what, got, want, $time);
	endtask

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r ^= a;
			a = xt(a);
		end
		return r;
	endfunction

	function automatic void build_boxes();
		logic [7:0] lg [256];
		logic [7:0] al [256];
		logic [7:0] p, b, s;
		p = 8'h01;
		for (int i = 0; i < 256; i++) lg[i] = 8'h00;
		for (int i = 0; i < 255; i++) begin
			al[i] = p;
			lg[p] = 8'(i);
			p = p ^ xt(p);
		end
		for (int i = 0; i < 256; i++) begin
			b = (i == 0) ? 8'h00 : al[(255 - int'(lg[i])) % 255];
			s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
				^ 8'd99;
			fwd_box[i] = s;
			inv_box[s] = 8'(i);
		end
	endfunction

	function automatic int columns(input logic [1:0] code);
		return 4 + 2 * ((code > 2) ? 2 : int'(code));
	endfunction

	function automatic int rounds();
		int kc, bc;
		kc = columns(key_code);
		bc = columns(blk_code);
		return (6 + ((kc > bc) ? kc : bc) > 14) ? 14 : 6 + ((kc > bc) ? kc : bc);
	endfunction

	function automatic logic [31:0] sub32(input logic [31:0] w);
		return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
	endfunction

	function automatic void expand_schedule();
		int kc, bc, total;
		logic [7:0] rc;
		logic [31:0] t;
		kc = columns(key_code);
		bc = columns(blk_code);
		total = (rounds() + 1) * bc;
		rc = 8'h01;
		for (int c = 0; c < kc && c < total; c++)
			sched[c] = c[0] ? key_reg[c / 2][31:0] : key_reg[c / 2][63:32];
		for (int c = kc; c < total; c++) begin
			t = sched[c - 1];
			if (c % kc == 0) begin
				t = sub32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = xt(rc);
			end else if (kc == 8 && c % kc == 4) begin
				t = sub32(t);
			end
			sched[c] = sched[c - kc] ^ t;
		end
		sched_ok = 1'b1;
	endfunction

	function automatic void cipher_block(ref logic [63:0] blk [4], input int nw);
		logic [7:0] st [4][8];
		logic [7:0] tmp [8];
		logic [7:0] a [4];
		int bc, nr, s, r;
		bc = columns(blk_code);
		nr = rounds();
		for (int n = 0; n < 8 * nw; n++) st[n % 4][n / 4] = blk[n / 8][63 - 8 * (n % 8) -: 8];
		for (int step = 0; step <= nr; step++) begin
			r = encrypt ? step : nr - step;
			if (step > 0) begin
				if (!encrypt && step > 1) begin
					for (int j = 0; j < bc; j++) begin
						for (int i = 0; i < 4; i++) a[i] = st[i][j];
						for (int i = 0; i < 4; i++)
							st[i][j] = gmul(a[i], 8'h0e) ^ gmul(a[(i + 1) % 4], 8'h0b)
								^ gmul(a[(i + 2) % 4], 8'h0d) ^ gmul(a[(i + 3) % 4], 8'h09);
					end
				end
				for (int i = 0; i < 4; i++)
					for (int j = 0; j < bc; j++)
						st[i][j] = encrypt ? fwd_box[st[i][j]] : inv_box[st[i][j]];
				for (int i = 1; i < 4; i++) begin
					s = (bc == 8 && i >= 2) ? i + 1 : i;
					if (!encrypt) s = bc - s;
					for (int j = 0; j < bc; j++) tmp[j] = st[i][(j + s) % bc];
					for (int j = 0; j < bc; j++) st[i][j] = tmp[j];
				end
				if (encrypt && step != nr) begin
					for (int j = 0; j < bc; j++) begin
						for (int i = 0; i < 4; i++) a[i] = st[i][j];
						for (int i = 0; i < 4; i++)
							st[i][j] = gmul(a[i], 8'h02) ^ gmul(a[(i + 1) % 4], 8'h03)
								^ a[(i + 2) % 4] ^ a[(i + 3) % 4];
					end
				end
			end
			// decrypt adds the key of the round below after the inverse steps
			if (!encrypt && step > 0) r = nr - step;
			for (int j = 0; j < bc; j++)
				for (int i = 0; i < 4; i++)
					st[i][j] ^= sched[r * bc + j][31 - 8 * i -: 8];
		end
		for (int n = 0; n < 8 * nw; n++) blk[n / 8][63 - 8 * (n % 8) -: 8] = st[n % 4][n / 4];
	endfunction

	// takes one accepted word, queues the block words it completes
	function automatic int predict_word(input logic op, input logic [63:0] data);
		int nw, idx;
		logic [63:0] blk [4];
		nw = columns(blk_code) / 2;
		if (op == OP_IV) begin
			chain[iv_cnt] = data;
			iv_cnt = (iv_cnt + 1 >= nw) ? 0 : iv_cnt + 1;
			fill_cnt = 0;
			return 0;
		end
		iv_cnt = 0;
		idx = fill_cnt;
		blk_buf[idx] = data;
		if (idx + 1 < nw) begin
			fill_cnt = idx + 1;
			return 0;
		end
		fill_cnt = 0;
		if (!sched_ok) expand_schedule();
		for (int k = 0; k < 4; k++)
			blk[k] = (cbc_on && encrypt && k < nw) ? blk_buf[k] ^ chain[k] : blk_buf[k];
		cipher_block(blk, nw);
		for (int k = 0; k < nw; k++) begin
			if (cbc_on) begin
				if (encrypt) begin
					chain[k] = blk[k];
				end else begin
					blk[k] ^= chain[k];
					chain[k] = blk_buf[k];
				end
			end
			cipher_q.push_back('{word: blk[k], last: (k + 1 == nw)});
		end
		n_blocks++;
		return nw;
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rbc_pkg::REG_KEY_SIZE: key_code = value[1:0];
			rbc_pkg::REG_BLOCK_SIZE: blk_code = value[1:0];
			rbc_pkg::REG_DIRECTION: encrypt = value[0];
			rbc_pkg::REG_CHAINING: cbc_on = value[0];
			default: key_reg[idx - rbc_pkg::REG_KEY_WORD_0] = value;
		endcase
		sched_ok = 1'b0;
	endtask

	task automatic send_word(input logic op, input logic [63:0] data);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		void'(predict_word(op, data));
	endtask

	// lets the last block drain with the input stream idle
	task automatic settle();
		s_tvalid <= 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			n_words++;
			if (cipher_q.size() == 0) begin
				report("unexpected word", m_tdata, 64'h0);
			end else begin
				if (m_tdata !== cipher_q[0].word) report("out_word", m_tdata, cipher_q[0].word);
				if (m_tlast !== cipher_q[0].last)
					report("last_word", 64'(m_tlast), 64'(cipher_q[0].last));
				void'(cipher_q.pop_front());
			end
		end
	end

	initial begin
		int stall;
		forever begin
			stall = hold_on ? 300 : (no_gaps ? 0 : $urandom_range(0, 4));
			hold_on = 1'b0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#3ms;
		$display("tb: failure");
		$finish;
	end

	stim_row_t walk [] = '{
		'{OP_DATA, 64'h0, 0, '{64'h0, 64'h0}},
		// all-zero key and block, the well known first vector
		'{OP_DATA, 64'h0, 2, '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}},
		'{OP_DATA, '1, 0, '{64'h0, 64'h0}},
		'{OP_DATA, '1, 0, '{64'h0, 64'h0}},
		'{OP_IV, '1, 0, '{64'h0, 64'h0}},
		'{OP_DATA, 64'h0123456789abcdef, 0, '{64'h0, 64'h0}},
		// iv word drops the partial block
		'{OP_IV, 64'h0, 0, '{64'h0, 64'h0}},
		'{OP_DATA, 64'h8000000000000001, 0, '{64'h0, 64'h0}},
		'{OP_DATA, 64'h5555aaaa5555aaaa, 0, '{64'h0, 64'h0}},
		'{OP_IV, 64'hfedcba9876543210, 0, '{64'h0, 64'h0}},
		'{OP_IV, 64'h0f0f0f0f0f0f0f0f, 0, '{64'h0, 64'h0}},
		'{OP_DATA, 64'haaaa5555aaaa5555, 0, '{64'h0, 64'h0}},
		'{OP_DATA, 64'h7fffffffffffffff, 0, '{64'h0, 64'h0}}
	};

	initial begin
		int cnt, nw, pick, got;
		logic [63:0] val;
		build_boxes();
		key_code = 2'd0;
		blk_code = 2'd0;
		encrypt = 1'b1;
		cbc_on = 1'b0;
		for (int k = 0; k < 4; k++) begin
			key_reg[k] = '0;
			blk_buf[k] = '0;
			chain[k] = '0;
		end
		fill_cnt = 0;
		iv_cnt = 0;
		sched_ok = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (walk[i]) begin
			send_word(walk[i].op, walk[i].data);
			for (int k = 0; k < walk[i].n_typed; k++) begin
				if (cipher_q[k].word !== walk[i].typed[k])
					report("known vector", cipher_q[k].word, walk[i].typed[k]);
			end
		end
		settle();

		// cbc on a fresh chain, then a block size that shrinks under a partial block
		reg_write(rbc_pkg::REG_CHAINING, 64'h1);
		reg_write(rbc_pkg::REG_BLOCK_SIZE, 64'h2);
		for (int k = 0; k < 7; k++) send_word(OP_DATA, {$urandom, $urandom});
		settle();
		reg_write(rbc_pkg::REG_BLOCK_SIZE, 64'h0);
		send_word(OP_DATA, '1);
		settle();
		reg_write(rbc_pkg::REG_DIRECTION, 64'h0);
		for (int k = 0; k < 4; k++) send_word(OP_DATA, {$urandom, $urandom});
		settle();

		for (int p = 0; p < 12; p++) begin
			n_phases++;
			no_gaps = (p % 4 == 1);
			reg_write(rbc_pkg::REG_KEY_SIZE, {32'($urandom), 30'h0, 2'(p % 4)});
			reg_write(rbc_pkg::REG_BLOCK_SIZE, {62'h0, 2'((p / 4 + p) % 4)});
			reg_write(rbc_pkg::REG_DIRECTION, {63'h0, 1'(p / 2)});
			reg_write(rbc_pkg::REG_CHAINING, {63'h0, 1'($urandom)});
			for (int k = 0; k < 4; k++) begin
				val = (p == 0) ? '1 : (p == 5 ? '0 : {$urandom, $urandom});
				reg_write(3'(rbc_pkg::REG_KEY_WORD_0 + k), val);
			end
			if (p == 3) hold_on = 1'b1;
			nw = columns(blk_code) / 2;
			cnt = 0;
			while (cnt < 30) begin
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					if (cbc_on && $urandom_range(0, 1)) begin
						for (int k = 0; k < nw; k++) send_word(OP_IV, {$urandom, $urandom});
						cnt += nw;
					end
					got = $urandom_range(1, 3);
					for (int b = 0; b < got * nw; b++) send_word(OP_DATA, {$urandom, $urandom});
					cnt += got * nw;
				end else begin
					send_word(1'($urandom), {$urandom, $urandom});
					cnt++;
				end
			end
			no_gaps = 1'b0;
			settle();
		end

		$display("tb: %0d blocks, %0d words checked over %0d register settings",
			n_blocks, n_words, n_phases + 4);
		$display("tb: all key and block sizes, both directions, ecb and cbc, long sink stall");
		if (n_fail == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire
